// ----- src/ovl_pkg.sv -----
// package for the ordered value list: payload types, codes and constants
package ovl_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int VALUE_W          = 32;
  localparam int ENTRY_COUNT_W    = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_MODIFY  = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] new_value;
  } ovl_in_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
    logic                       last;
  } ovl_out_t;

  // per-cell control: shift toward the head, or load the broadcast value
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- src/ovl_cell.sv -----
// one storage cell of the list chain
module ovl_cell (
  input  logic                       clk,
  input  ovl_pkg::cell_ctrl_t        ctrl,
  input  logic [ovl_pkg::VALUE_W-1:0] load_value,
  input  logic [ovl_pkg::VALUE_W-1:0] from_next,
  output logic [ovl_pkg::VALUE_W-1:0] data
);

  // load wins over shift: the tail cell takes the recirculated head
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_value;
    end else if (ctrl.shift) begin
      data <= from_next;
    end
  end

endmodule

// ----- src/ordered_value_list.sv -----
// top level of the ordered value list: cell chain, sequencer and output register
//
// Ordered list of up to CAPACITY signed 32-bit values, empty after reset. Entries live in a
// row of cells with the head in cell 0. Insert writes the cell just past the tail and
// needs no rotation; neither does any operation on an empty list. Delete, modify and display
// rotate the whole list once through the chain, one entry per cycle while the output
// register can take a result: each step compares or emits the head, every cell hands its
// value to its neighbor toward the head, and the head value re-enters at the tail (dropped
// on the first delete match, replaced by new_value on the first modify match). Those
// operations pause while the output side is stalled, and the next transaction is accepted
// once the rotation is done.
// Display gives one result transaction per entry, at most 16, the final one marked with last;
// every other operation gives exactly one result transaction. Results sit in an output
// register, so the input side waits on the output only while that register holds a
// stalled result.
module ordered_value_list #(
  parameter int CAPACITY = ovl_pkg::CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ovl_pkg::ovl_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ovl_pkg::ovl_out_t out_data
);

  // count width holds CAPACITY itself
  localparam int CW = $clog2(CAPACITY + 1);

  // list state
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // rotation sequencer state
  logic                        busy;
  logic [CW-1:0]               step;
  logic [CW-1:0]               span;
  logic                        found;
  ovl_pkg::op_t                op_r;
  logic [ovl_pkg::VALUE_W-1:0] val_r;
  logic [ovl_pkg::VALUE_W-1:0] nval_r;

  // cell chain wiring
  ovl_pkg::cell_ctrl_t         cell_ctrl [CAPACITY];
  logic [ovl_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [ovl_pkg::VALUE_W-1:0] cell_next [CAPACITY];
  logic [ovl_pkg::VALUE_W-1:0] head;
  logic                        chain_shift;
  logic                        chain_load;
  logic [CW-1:0]               load_pos;
  logic [ovl_pkg::VALUE_W-1:0] load_value;

  // handshake and step control
  logic out_free;
  logic in_go;
  logic step_go;
  logic step_end;
  logic is_match;
  logic drop;
  logic repl;
  logic ins_ok;
  logic start;

  // result staging
  logic              res_load;
  ovl_pkg::ovl_out_t res;

  assign head = cell_data[0];

  // output register frees up when empty or when its transaction is taken
  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy || !out_free;
  assign in_go    = in_valid && !in_stall;

  // one rotation step per cycle while the result path can take a transaction
  assign step_go  = busy && out_free;
  assign step_end = (step == span - CW'(1));
  assign is_match = (head == val_r);
  assign drop     = step_go && (op_r == ovl_pkg::OP_DELETE) && is_match && !found;
  assign repl     = step_go && (op_r == ovl_pkg::OP_MODIFY) && is_match && !found;

  // insert has room, or a non-empty list starts a rotation
  assign ins_ok = in_go && (in_data.op == ovl_pkg::OP_INSERT) && (count < CW'(CAPACITY));
  assign start  = in_go && (in_data.op != ovl_pkg::OP_INSERT) && (count != '0);

  always_comb begin
    if (ins_ok) begin
      count_next = count + CW'(1);
    end else if (drop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  // chain control: insert writes past the tail, a rotation step shifts and
  // recirculates the head into the current tail slot
  assign chain_shift = step_go;
  assign chain_load  = ins_ok || (step_go && !drop);
  assign load_pos    = ins_ok ? count : (count - CW'(1));

  always_comb begin
    if (ins_ok) begin
      load_value = in_data.value;
    end else if (repl) begin
      load_value = nval_r;
    end else begin
      load_value = head;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i].shift = chain_shift;
    assign cell_ctrl[i].load  = chain_load && (load_pos == CW'(i));

    // last cell has no neighbor; its shifted value lies beyond the tail
    if (i == CAPACITY - 1) begin : g_end
      assign cell_next[i] = cell_data[i];
    end else begin : g_mid
      assign cell_next[i] = cell_data[i+1];
    end

    ovl_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .load_value (load_value),
      .from_next  (cell_next[i]),
      .data       (cell_data[i])
    );
  end

  // result selection: immediate results at accept, else from the rotation
  always_comb begin
    res_load         = 1'b0;
    res.status       = ovl_pkg::ST_OK;
    res.entry_value  = '0;
    res.entry_count  = ovl_pkg::ENTRY_COUNT_W'(count_next);
    res.last         = 1'b1;
    if (in_go) begin
      res_load = (in_data.op == ovl_pkg::OP_INSERT) || (count == '0);
      case (in_data.op)
        ovl_pkg::OP_INSERT: res.status = ins_ok ? ovl_pkg::ST_OK : ovl_pkg::ST_FULL;
        ovl_pkg::OP_DELETE: res.status = ovl_pkg::ST_NOT_FOUND;
        default:            res.status = ovl_pkg::ST_EMPTY;
      endcase
    end else if (step_go) begin
      if (op_r == ovl_pkg::OP_DISPLAY) begin
        // only the first entries are shown, the rest still rotate back into place
        res_load        = (32'(step) < ovl_pkg::MAX_RESULTS);
        res.entry_value = head;
        res.last        = step_end || (32'(step) == ovl_pkg::MAX_RESULTS - 1);
      end else begin
        res_load   = step_end;
        res.status = (found || drop || repl) ? ovl_pkg::ST_OK : ovl_pkg::ST_NOT_FOUND;
      end
    end
  end

  // list count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // rotation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      found <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      found <= 1'b0;
    end else if (step_go) begin
      found <= found || drop || repl;
      if (step_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step   <= '0;
      span   <= count;
      op_r   <= in_data.op;
      val_r  <= in_data.value;
      nval_r <= in_data.new_value;
    end else if (step_go) begin
      step <= step + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  // the list never holds more than it has cells for
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("list count above capacity");

  // a rotation never runs past the entries it started with
  assert property (@(posedge clk) disable iff (rst) busy |-> (step < span))
    else $error("rotation step beyond its span");

  // display leaves the count alone
  assert property (@(posedge clk) disable iff (rst)
    (step_go && (op_r == ovl_pkg::OP_DISPLAY)) |=> (count == $past(count)))
    else $error("display changed the list count");

  // only delete and modify can record a match
  assert property (@(posedge clk) disable iff (rst)
    found |-> ((op_r == ovl_pkg::OP_DELETE) || (op_r == ovl_pkg::OP_MODIFY)))
    else $error("match recorded for an operation that does not search");

  // a delete that removes an entry ends with one entry fewer
  assert property (@(posedge clk) disable iff (rst)
    (step_go && step_end && (op_r == ovl_pkg::OP_DELETE) && (found || drop))
      |=> (count == $past(span) - CW'(1)))
    else $error("delete did not shrink the list by one");
`endif

endmodule

// ----- dv/tb_ordered_value_list.sv -----
// self-checking testbench for the ordered value list: table-driven and random list operations
module tb_ordered_value_list;
  timeunit 1ns;
  timeprecision 1ps;

  import ovl_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEFAULT;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 390;
  localparam int HOLD_AFTER_ITEMS = 220;  // accepted transactions before the long output hold
  localparam int LONG_HOLD = 300;         // cycles the receiver holds off in one stretch
  localparam int SETTLE_CYCLES = 40;      // quiet time after the last result

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ovl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ovl_out_t out_data;

  // shadow copy of the list, head at index 0
  logic signed [VALUE_W-1:0] shadow_list[$];
  // results caused by the transaction just applied to the shadow list
  ovl_out_t list_op_results[$];
  // results still owed by the block, oldest first
  ovl_out_t owed_results[$];
  ovl_out_t owed_head;

  int  errors = 0;
  int  accepted_ops = 0;
  int  burst_left = 0;
  bit  filling = 1'b1;       // random ops lean toward inserts while set, deletes otherwise
  bit  hold_request = 1'b0;
  bit  hold_served = 1'b0;

  // directed table: expected status and count typed in where they are obvious,
  // otherwise the shadow list decides; reps > 1 repeats the row with value + 1 each time
  typedef struct {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] new_value;
    int                        reps;
    bit                        typed;
    status_t                   status;
    int                        count;
  } plan_row_t;

  localparam int PLAN_ROWS = 19;
  plan_row_t plan [PLAN_ROWS] = '{
    // delete, modify and display on an empty list
    '{OP_DISPLAY, 0,         0,         1,  1'b1, ST_EMPTY,     0},
    '{OP_DELETE,  5,         0,         1,  1'b1, ST_NOT_FOUND, 0},
    '{OP_MODIFY,  5,         9,         1,  1'b1, ST_EMPTY,     0},
    // extremes, zero, minus one and a duplicate pair
    '{OP_INSERT,  VALUE_MIN, 0,         1,  1'b1, ST_OK,        1},
    '{OP_INSERT,  VALUE_MAX, 0,         1,  1'b1, ST_OK,        2},
    '{OP_INSERT,  0,         0,         1,  1'b1, ST_OK,        3},
    '{OP_INSERT,  -1,        0,         1,  1'b1, ST_OK,        4},
    '{OP_INSERT,  7,         0,         1,  1'b1, ST_OK,        5},
    '{OP_INSERT,  7,         0,         1,  1'b1, ST_OK,        6},
    // duplicates: only the first match from the head is touched
    '{OP_MODIFY,  7,         VALUE_MAX, 1,  1'b0, ST_OK,        0},
    '{OP_DELETE,  7,         0,         1,  1'b0, ST_OK,        0},
    // misses leave the list alone
    '{OP_DELETE,  1234,      0,         1,  1'b1, ST_NOT_FOUND, 5},
    '{OP_MODIFY,  1234,      VALUE_MIN, 1,  1'b1, ST_NOT_FOUND, 5},
    // fill to capacity, then one insert too many
    '{OP_INSERT,  100,       0,         11, 1'b0, ST_OK,        0},
    '{OP_INSERT,  55,        0,         1,  1'b1, ST_FULL,      16},
    '{OP_DISPLAY, 0,         0,         1,  1'b0, ST_OK,        0},
    // delete the head, then hit the first of two max entries
    '{OP_DELETE,  VALUE_MIN, 0,         1,  1'b0, ST_OK,        0},
    '{OP_MODIFY,  VALUE_MAX, VALUE_MIN, 1,  1'b0, ST_OK,        0},
    '{OP_DISPLAY, 0,         0,         1,  1'b0, ST_OK,        0}
  };

  ordered_value_list #(
    .CAPACITY (LIST_CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // apply one transaction to the shadow list and collect the results it causes
  function automatic void apply_list_op(input ovl_in_t t);
    int       hit;
    int       n;
    ovl_out_t r;
    list_op_results.delete();
    hit = -1;
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (hit < 0 && shadow_list[i] == t.value) hit = i;
    end
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (t.op)
      OP_INSERT: begin
        if (shadow_list.size() >= LIST_CAP) r.status = ST_FULL;
        else shadow_list.push_back(t.value);
      end
      OP_DELETE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else shadow_list.delete(hit);
      end
      OP_MODIFY: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else if (hit < 0) r.status = ST_NOT_FOUND;
        else shadow_list[hit] = t.new_value;
      end
      default: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // one result per entry, head first, capped at the result limit
          n = shadow_list.size();
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          for (int i = 0; i < n; i++) begin
            r.entry_value = shadow_list[i];
            r.entry_count = ENTRY_COUNT_W'(shadow_list.size());
            r.last = (i + 1 == n);
            list_op_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.entry_count = ENTRY_COUNT_W'(shadow_list.size());
    list_op_results.push_back(r);
  endfunction

  // small values and the extremes, so that duplicates and hits are common
  function automatic logic signed [VALUE_W-1:0] pool_value();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      default: return VALUE_W'(k - 6);
    endcase
  endfunction

  // random transaction: fill phases and drain phases so the list swings between
  // empty and full, with values mostly taken from what the list holds
  function automatic ovl_in_t pick_list_op();
    ovl_in_t t;
    int      r;
    int      k;
    if (shadow_list.size() >= LIST_CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (shadow_list.size() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 12) t.op = OP_DISPLAY;
    else if (filling) t.op = (r < 72) ? OP_INSERT : ((r < 86) ? OP_DELETE : OP_MODIFY);
    else t.op = (r < 60) ? OP_DELETE : ((r < 80) ? OP_MODIFY : OP_INSERT);
    k = $urandom_range(0, 9);
    if (k < 5 && shadow_list.size() != 0)
      t.value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    else if (k < 8)
      t.value = pool_value();
    else
      t.value = $urandom;
    t.new_value = ($urandom_range(0, 1) == 0) ? pool_value() : $urandom;
    return t;
  endfunction

  // offer one transaction, hold it until accepted, then log what the block owes
  task automatic send_list_op(input ovl_in_t t, input bit typed, input status_t status,
                              input int count);
    ovl_out_t r;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    apply_list_op(t);
    if (typed) begin
      r = '0;
      r.status = status;
      r.entry_count = ENTRY_COUNT_W'(count);
      r.last = 1'b1;
      owed_results.push_back(r);
    end else begin
      foreach (list_op_results[i]) owed_results.push_back(list_op_results[i]);
    end
    accepted_ops++;
    if (accepted_ops == HOLD_AFTER_ITEMS) hold_request = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      // gap between bursts; now and then a long burst with no gap pressure at all
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // sender: reset, directed table, random transactions, then drain and report
  initial begin : sender
    ovl_in_t item;
    burst_left = $urandom_range(1, 10);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[row]) begin
      for (int rep = 0; rep < plan[row].reps; rep++) begin
        item.op = plan[row].op;
        item.value = plan[row].value + rep;
        item.new_value = plan[row].new_value;
        send_list_op(item, plan[row].typed, plan[row].status, plan[row].count);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_list_op(pick_list_op(), 1'b0, ST_OK, 0);
    end
    in_valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    // any late result here has nothing waiting for it and is flagged by the checker
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: stall phases of random density, plus one long hold so the
  // output register fills and the block pushes back on its input
  initial begin : receiver
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 85;
        endcase
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // checker: each accepted result against the oldest owed one, field by field
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result transaction with nothing owed: %p", out_data);
        errors++;
      end else begin
        owed_head = owed_results.pop_front();
        if (out_data.status !== owed_head.status) begin
          $error("status: expected %s, got %0d", owed_head.status.name(), out_data.status);
          errors++;
        end
        if (out_data.entry_value !== owed_head.entry_value) begin
          $error("entry_value: expected %0d, got %0d", owed_head.entry_value,
                 out_data.entry_value);
          errors++;
        end
        if (out_data.entry_count !== owed_head.entry_count) begin
          $error("entry_count: expected %0d, got %0d", owed_head.entry_count,
                 out_data.entry_count);
          errors++;
        end
        if (out_data.last !== owed_head.last) begin
          $error("last: expected %0b, got %0b", owed_head.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
